// ----- hw/rtl/crg_pkg.sv -----
// Shared types, codes and safe-value arithmetic for the clock request guard.
package crg_pkg;

    localparam int CoreW  = 13;
    localparam int MemW   = 14;
    localparam int VoltW  = 12;
    localparam int TempW  = 8;
    localparam int PowerW = 10;
    localparam int CountW = 16;
    localparam int StatW  = 3;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 14;

    // opcodes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // status codes
    localparam logic [StatW-1:0] ST_OK      = 3'd0;
    localparam logic [StatW-1:0] ST_CORE    = 3'd1;
    localparam logic [StatW-1:0] ST_MEM     = 3'd2;
    localparam logic [StatW-1:0] ST_VOLT    = 3'd3;
    localparam logic [StatW-1:0] ST_HOT     = 3'd4;
    localparam logic [StatW-1:0] ST_LOW_V   = 3'd5;
    localparam logic [StatW-1:0] ST_STEP    = 3'd6;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_CORE_LIMIT  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MEM_LIMIT   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_VOLT_LIMIT  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TEMP_LIMIT  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_POWER_LIMIT = 3'd4;

    localparam int CoreLimitRst  = 2000;
    localparam int MemLimitRst   = 8000;
    localparam int VoltLimitRst  = 1100;
    localparam int TempLimitRst  = 85;
    localparam int PowerLimitRst = 250;

    localparam logic [CoreW-1:0]  CORE_LIMIT_RST  = CoreW'(CoreLimitRst);
    localparam logic [MemW-1:0]   MEM_LIMIT_RST   = MemW'(MemLimitRst);
    localparam logic [VoltW-1:0]  VOLT_LIMIT_RST  = VoltW'(VoltLimitRst);
    localparam logic [TempW-1:0]  TEMP_LIMIT_RST  = TempW'(TempLimitRst);
    localparam logic [PowerW-1:0] POWER_LIMIT_RST = PowerW'(PowerLimitRst);

    localparam logic [CoreW-1:0] SAFE_CORE_RST = CoreW'(CoreLimitRst * 80 / 100);
    localparam logic [MemW-1:0]  SAFE_MEM_RST  = MemW'(MemLimitRst * 90 / 100);
    localparam logic [VoltW-1:0] SAFE_VOLT_RST = VoltW'(VoltLimitRst * 90 / 100);

    localparam logic [CoreW-1:0]  LOW_V_CORE  = 13'd1500;
    localparam logic [VoltW-1:0]  LOW_V_VOLT  = 12'd1000;
    localparam logic [CountW-1:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [CountW-1:0] FALLBACK_AT = 16'd3;

    typedef struct packed {
        logic              opcode;
        logic [CoreW-1:0]  core;
        logic [MemW-1:0]   mem;
        logic [VoltW-1:0]  volt;
        logic [TempW-1:0]  temp;
        logic [PowerW-1:0] power;
    } item_t;

    typedef struct packed {
        logic [CoreW-1:0]  core;
        logic [MemW-1:0]   mem;
        logic [VoltW-1:0]  volt;
        logic [TempW-1:0]  temp;
        logic [PowerW-1:0] power;
        logic [CountW-1:0] rejections;
    } state_t;

    typedef struct packed {
        logic [CoreW-1:0]  core;
        logic [MemW-1:0]   mem;
        logic [VoltW-1:0]  volt;
        logic [TempW-1:0]  temp;
        logic [PowerW-1:0] power;
        logic [CoreW-1:0]  safe_core;
        logic [MemW-1:0]   safe_mem;
        logic [VoltW-1:0]  safe_volt;
    } limits_t;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic             fallback;
        state_t           next;
    } verdict_t;

    // floor(n/10) for n < 2^18: reciprocal 2^22/10 rounded up, error 6 keeps it exact
    function automatic logic [14:0] div10(input logic [17:0] n);
        logic [36:0] prod;
        prod = {19'd0, n} * 37'd419431;
        return prod[36:22];
    endfunction

    // floor(n/5) for n < 2^15: reciprocal 2^18/5 rounded up, error 1
    function automatic logic [13:0] div5(input logic [14:0] n);
        logic [31:0] prod;
        prod = {17'd0, n} * 32'd52429;
        return prod[31:18];
    endfunction

    function automatic logic [CoreW-1:0] safe_core(input logic [CoreW-1:0] lim);
        logic [13:0] q;
        q = div5({lim, 2'b00});
        return q[CoreW-1:0];
    endfunction

    function automatic logic [MemW-1:0] safe_mem(input logic [MemW-1:0] lim);
        logic [14:0] q;
        q = div10({4'd0, lim} * 18'd9);
        return q[MemW-1:0];
    endfunction

    function automatic logic [VoltW-1:0] safe_volt(input logic [VoltW-1:0] lim);
        logic [14:0] q;
        q = div10({6'd0, lim} * 18'd9);
        return q[VoltW-1:0];
    endfunction

endpackage

// ----- hw/rtl/clock_request_guard_core.sv -----
// Top level of the clock request guard: input register, state, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  in       | in_valid / in_stall  | opcode core_mhz memory_clock voltage
//           |                      | temperature power
//  out      | out_valid/ out_stall | status fallback_applied core_setting
//           |                      | memory_setting voltage_setting rejected_count
//  cfg      | cfg_write            | cfg_index cfg_data
//
// A beat passes the input register, then the result register; one beat per cycle sustained while out_stall is low.
// The settings state updates as a beat moves from the input to the result register,
// so the following beat sees it at once.
// Reset clears the settings state and valid flags and loads the default limits; no clearing pass.
// A stalled result holds; the input register keeps taking a beat while it is free.
module clock_request_guard_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [crg_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [crg_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [crg_pkg::CoreW-1:0]     core_mhz,
    input  logic [crg_pkg::MemW-1:0]      memory_clock,
    input  logic [crg_pkg::VoltW-1:0]     voltage,
    input  logic [crg_pkg::TempW-1:0]     temperature,
    input  logic [crg_pkg::PowerW-1:0]    power,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [crg_pkg::StatW-1:0]     status,
    output logic                          fallback_applied,
    output logic [crg_pkg::CoreW-1:0]     core_setting,
    output logic [crg_pkg::MemW-1:0]      memory_setting,
    output logic [crg_pkg::VoltW-1:0]     voltage_setting,
    output logic [crg_pkg::CountW-1:0]    rejected_count
);

    crg_pkg::limits_t  limits;
    crg_pkg::verdict_t verdict;
    crg_pkg::item_t    item_reg;
    crg_pkg::state_t   state_reg;
    crg_pkg::verdict_t result_reg;

    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic process;
    logic take_in;

    crg_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    crg_judge u_judge (
        .item    (item_reg),
        .state   (state_reg),
        .limits  (limits),
        .verdict (verdict)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign process  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (process)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process)
                state_reg <= verdict.next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.opcode <= opcode;
            item_reg.core   <= core_mhz;
            item_reg.mem    <= memory_clock;
            item_reg.volt   <= voltage;
            item_reg.temp   <= temperature;
            item_reg.power  <= power;
        end
        if (process)
            result_reg <= verdict;
    end

    assign out_valid        = out_valid_reg;
    assign status           = result_reg.status;
    assign fallback_applied = result_reg.fallback;
    assign core_setting     = result_reg.next.core;
    assign memory_setting   = result_reg.next.mem;
    assign voltage_setting  = result_reg.next.volt;
    assign rejected_count   = result_reg.next.rejections;

    // rejection counter saturates, never wraps back
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.rejections >= $past(state_reg.rejections))
        else $error("rejection counter went backwards");

    // once past the attempt threshold every rejection must fall back
    a_reject_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        process && verdict.status != crg_pkg::ST_OK
            && verdict.next.rejections > crg_pkg::FALLBACK_AT |=> result_reg.fallback)
        else $error("rejection past threshold without fallback");

    // a held result must not be overwritten by a beat in the input register
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(result_reg))
        else $error("stalled result overwritten");

    // state only moves when a beat passes into the result register
    a_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> $stable(state_reg))
        else $error("state changed without a beat");

endmodule

// ----- hw/rtl/crg_config.sv -----
// Limit registers and the safe settings derived from them at write time.
module crg_config (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [crg_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [crg_pkg::CfgDataW-1:0]  cfg_data,
    output crg_pkg::limits_t              limits
);

    crg_pkg::limits_t lim_reg;
    crg_pkg::limits_t lim_next;

    always_comb
    begin
        lim_next = lim_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                crg_pkg::CFG_CORE_LIMIT:
                begin
                    lim_next.core      = cfg_data[crg_pkg::CoreW-1:0];
                    lim_next.safe_core = crg_pkg::safe_core(cfg_data[crg_pkg::CoreW-1:0]);
                end
                crg_pkg::CFG_MEM_LIMIT:
                begin
                    lim_next.mem      = cfg_data[crg_pkg::MemW-1:0];
                    lim_next.safe_mem = crg_pkg::safe_mem(cfg_data[crg_pkg::MemW-1:0]);
                end
                crg_pkg::CFG_VOLT_LIMIT:
                begin
                    lim_next.volt      = cfg_data[crg_pkg::VoltW-1:0];
                    lim_next.safe_volt = crg_pkg::safe_volt(cfg_data[crg_pkg::VoltW-1:0]);
                end
                crg_pkg::CFG_TEMP_LIMIT:  lim_next.temp  = cfg_data[crg_pkg::TempW-1:0];
                crg_pkg::CFG_POWER_LIMIT: lim_next.power = cfg_data[crg_pkg::PowerW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.core      <= crg_pkg::CORE_LIMIT_RST;
            lim_reg.mem       <= crg_pkg::MEM_LIMIT_RST;
            lim_reg.volt      <= crg_pkg::VOLT_LIMIT_RST;
            lim_reg.temp      <= crg_pkg::TEMP_LIMIT_RST;
            lim_reg.power     <= crg_pkg::POWER_LIMIT_RST;
            lim_reg.safe_core <= crg_pkg::SAFE_CORE_RST;
            lim_reg.safe_mem  <= crg_pkg::SAFE_MEM_RST;
            lim_reg.safe_volt <= crg_pkg::SAFE_VOLT_RST;
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    assign limits = lim_reg;

endmodule

// ----- hw/rtl/crg_judge.sv -----
// Single-pass check chain, counter update and fallback selection for one item.
module crg_judge (
    input  crg_pkg::item_t    item,
    input  crg_pkg::state_t   state,
    input  crg_pkg::limits_t  limits,
    output crg_pkg::verdict_t verdict
);

    // threshold checks scaled up so no division is needed:
    // t > floor(9L/10) <=> 10t > 9L, c > floor(11n/10) <=> 10c > 11n
    logic [16:0] core_x10;
    logic [16:0] now_x11;
    logic [11:0] temp_x10;
    logic [11:0] lim_x9;
    logic [crg_pkg::StatW-1:0]  status;
    logic                       fallback;
    logic                       force_safe;
    crg_pkg::state_t            next;

    assign core_x10 = {4'd0, item.core} * 17'd10;
    assign now_x11  = {4'd0, state.core} * 17'd11;
    assign temp_x10 = {4'd0, state.temp} * 12'd10;
    assign lim_x9   = {4'd0, limits.temp} * 12'd9;

    always_comb
    begin
        status     = crg_pkg::ST_OK;
        force_safe = 1'b0;
        next       = state;
        if (item.opcode == crg_pkg::OP_REQUEST)
        begin
            if (item.core > limits.core)
                status = crg_pkg::ST_CORE;
            else if (item.mem > limits.mem)
                status = crg_pkg::ST_MEM;
            else if (item.volt > limits.volt)
                status = crg_pkg::ST_VOLT;
            else if (temp_x10 > lim_x9)
                status = crg_pkg::ST_HOT;
            else if (item.core > crg_pkg::LOW_V_CORE && item.volt < crg_pkg::LOW_V_VOLT)
                status = crg_pkg::ST_LOW_V;
            else if (state.core != '0 && core_x10 > now_x11)
                status = crg_pkg::ST_STEP;

            if (status != crg_pkg::ST_OK)
            begin
                if (state.rejections != crg_pkg::COUNT_MAX)
                    next.rejections = state.rejections + 16'd1;
                force_safe = next.rejections > crg_pkg::FALLBACK_AT;
            end
            else
            begin
                next.core = item.core;
                next.mem  = item.mem;
                next.volt = item.volt;
            end
        end
        else
        begin
            next.temp  = item.temp;
            next.power = item.power;
            force_safe = (item.temp > limits.temp) || (item.power > limits.power);
        end

        fallback = force_safe;
        if (force_safe)
        begin
            next.core = limits.safe_core;
            next.mem  = limits.safe_mem;
            next.volt = limits.safe_volt;
        end
    end

    assign verdict.status   = status;
    assign verdict.fallback = fallback;
    assign verdict.next     = next;

endmodule
